/* design/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, masked while reset is held
`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, masked while reset is held
`define ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// next-cycle implication, also checked across reset
`define ASSERT_NXT_ALL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* design/pipft_pkg.sv */
package pipft_pkg;

  // fixed field widths
  localparam int TOL_W  = 32;
  localparam int HIT_W  = 6;
  localparam int OUT_W  = 16;
  localparam int PC_W   = 4;

  localparam logic [HIT_W-1:0] HIT_MAX = '1;

  typedef logic [PC_W-1:0] pc_t;

  localparam pc_t FIN_PC = 4'd12;

  // coordinate picked for one side of a difference
  typedef enum logic [2:0] {
    CS_QX, CS_QY, CS_X0, CS_Y0, CS_X1, CS_Y1, CS_X2, CS_Y2
  } coord_sel_t;

  // what the shared multiplier is fed with
  typedef enum logic [1:0] {
    MM_DIFF, MM_EPS_LO, MM_EPS_HI
  } mul_mode_t;

  // what happens to the product registered in the previous step
  typedef enum logic [2:0] {
    AO_NONE, AO_LOAD, AO_SUB, AO_MAGLOAD, AO_ELOAD, AO_EADD, AO_TESTLOAD, AO_TESTHIT
  } acc_op_t;

  // sequencing of the step counter
  typedef enum logic [1:0] {
    SQ_NEXT, SQ_JNT, SQ_FIN
  } seq_op_t;

  typedef struct packed {
    coord_sel_t a_u;
    coord_sel_t a_v;
    coord_sel_t b_u;
    coord_sel_t b_v;
    mul_mode_t  mm;
    acc_op_t    ao;
    seq_op_t    sq;
    pc_t        target;
  } ucode_t;

  // result request, first field in the highest bits
  typedef struct packed {
    logic [6:0]       pad;
    logic             overflow;
    logic             too_few;
    logic [HIT_W-1:0] hit_triangle;
    logic             inside_res;
  } out_item_t;

  function automatic ucode_t uc_word(coord_sel_t au, coord_sel_t av, coord_sel_t bu,
                                     coord_sel_t bv, mul_mode_t mm, acc_op_t ao,
                                     seq_op_t sq);
    ucode_t w;
    w.a_u    = au;
    w.a_v    = av;
    w.b_u    = bu;
    w.b_v    = bv;
    w.mm     = mm;
    w.ao     = ao;
    w.sq     = sq;
    w.target = FIN_PC;
    return w;
  endfunction

  // control store: one fan triangle test
  // x0/y0 anchor, x1/y1 previous vertex, x2/y2 current vertex
  function automatic ucode_t uc_rom(pc_t pc);
    ucode_t w;
    unique case (pc)
      // orientation product, skip to finish when no triangle is due
      4'd0:  w = uc_word(CS_X1, CS_X0, CS_Y2, CS_Y0, MM_DIFF,   AO_NONE,     SQ_JNT);
      4'd1:  w = uc_word(CS_Y1, CS_Y0, CS_X2, CS_X0, MM_DIFF,   AO_LOAD,     SQ_NEXT);
      4'd2:  w = uc_word(CS_QX, CS_X0, CS_QY, CS_Y1, MM_DIFF,   AO_SUB,      SQ_NEXT);
      // sign and magnitude, first edge product
      4'd3:  w = uc_word(CS_QY, CS_Y0, CS_QX, CS_X1, MM_DIFF,   AO_MAGLOAD,  SQ_NEXT);
      4'd4:  w = uc_word(CS_QX, CS_QX, CS_QX, CS_QX, MM_EPS_LO, AO_SUB,      SQ_NEXT);
      // tolerance in two partial products
      4'd5:  w = uc_word(CS_QX, CS_QX, CS_QX, CS_QX, MM_EPS_HI, AO_ELOAD,    SQ_NEXT);
      4'd6:  w = uc_word(CS_QX, CS_X1, CS_QY, CS_Y2, MM_DIFF,   AO_EADD,     SQ_NEXT);
      // edge from the previous vertex to the current one
      4'd7:  w = uc_word(CS_QY, CS_Y1, CS_QX, CS_X2, MM_DIFF,   AO_TESTLOAD, SQ_NEXT);
      4'd8:  w = uc_word(CS_QX, CS_X2, CS_QY, CS_Y0, MM_DIFF,   AO_SUB,      SQ_NEXT);
      // edge from the current vertex back to the anchor
      4'd9:  w = uc_word(CS_QY, CS_Y2, CS_QX, CS_X0, MM_DIFF,   AO_TESTLOAD, SQ_NEXT);
      4'd10: w = uc_word(CS_QX, CS_QX, CS_QX, CS_QX, MM_DIFF,   AO_SUB,      SQ_NEXT);
      4'd11: w = uc_word(CS_QX, CS_QX, CS_QX, CS_QX, MM_DIFF,   AO_TESTHIT,  SQ_NEXT);
      // vertex bookkeeping and result
      default: w = uc_word(CS_QX, CS_QX, CS_QX, CS_QX, MM_DIFF, AO_NONE,     SQ_FIN);
    endcase
    return w;
  endfunction

endpackage

/* design/point_in_polygon_fan_test.sv */
// point-in-polygon test over a fan of triangles sharing the first vertex
// in_*  : one polygon vertex per request; tdata holds query_x, query_y,
//         vert_x, vert_y (COORD_BITS each, signed); tlast marks the final vertex.
//         the query point is taken from the first vertex of a polygon.
// out_* : one result per polygon, sent after the request carrying tlast.
// cfg_* : writes tol_frac, the tolerance fraction scaled by 2^-32.
// a vertex that closes a fan triangle while no hit is known yet runs all 13
// control-store steps, 0 to 12, as the single shared multiplier does ten
// products in turn; other vertices jump from step 0 to the finishing step 12.
// out_tvalid is registered; it rises once the finishing step has run for
// the vertex carrying tlast and the result register has been loaded.
// one vertex is worked on at a time; in_tready is low while it is in flight.
// a finished result sits in the output register; the next polygon proceeds
// while it waits, and only the next closing vertex holds if it is not taken.
// reset (synchronous, active low) clears the polygon state, drops out_tvalid
// and sets tol_frac to zero. no clearing pass is needed.
module point_in_polygon_fan_test
  import pipft_pkg::*;
#(
  parameter int MAX_VERTICES = 64,
  parameter int COORD_BITS   = 24
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // query_x, query_y, vert_x, vert_y from bit 0 up
  input  logic [((4*COORD_BITS+7)/8)*8-1:0]      in_tdata,
  input  logic                                   in_tlast,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // inside_res, hit_triangle, too_few, overflow from bit 0 up
  output logic [OUT_W-1:0]                       out_tdata,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [TOL_W-1:0]                       cfg_data
);

  localparam int CB    = COORD_BITS;
  localparam int DW    = CB + 1;
  localparam int HW    = CB + 1;
  localparam int CW    = 2 * CB + 3;
  localparam int MW    = (CB + 2 > TOL_W + 1) ? CB + 2 : TOL_W + 1;
  localparam int EW    = 2 * HW + TOL_W;
  localparam int TW    = CW + TOL_W + 2;
  localparam int CNT_W = $clog2(MAX_VERTICES + 1);

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_VERTICES);

  // control state
  logic             busy_r, busy_nxt;
  pc_t              pc_r, pc_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             hit_flag_r, hit_flag_nxt;
  logic [HIT_W-1:0] hit_idx_r, hit_idx_nxt;
  logic             ovf_r, ovf_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [TOL_W-1:0] tol_r;

  // datapath registers
  logic signed [CB-1:0]   qx_r, qy_r, x0_r, y0_r, x1_r, y1_r, x2_r, y2_r;
  logic                   last_r;
  logic                   pass_r;
  logic                   flip_r;
  logic signed [2*MW-1:0] mul_r;
  logic signed [CW-1:0]   acc_r;
  logic [2*HW-1:0]        mag_r;
  logic [EW-1:0]          eps_r;
  out_item_t              out_data_r;

  ucode_t                 uc;
  logic signed [CB-1:0]   au, av, bu, bv;
  logic signed [DW-1:0]   diff_a, diff_b;
  logic signed [MW-1:0]   mul_a, mul_b;
  logic [CW-1:0]          acc_abs;
  logic signed [CW:0]     p_ext, p_sgn;
  logic signed [TW-1:0]   tsum;
  logic                   test_ok;
  logic                   tri_needed;
  logic                   fin_block, fin_go, fin_load;
  logic                   in_acc;
  logic [CNT_W-1:0]       tri_k;
  logic [HIT_W-1:0]       tri_k_sat;
  logic [CNT_W-1:0]       cnt_after;
  logic                   ovf_after;

  function automatic logic signed [CB-1:0] pick(
    coord_sel_t s,
    logic signed [CB-1:0] qx, logic signed [CB-1:0] qy,
    logic signed [CB-1:0] x0, logic signed [CB-1:0] y0,
    logic signed [CB-1:0] x1, logic signed [CB-1:0] y1,
    logic signed [CB-1:0] x2, logic signed [CB-1:0] y2
  );
    logic signed [CB-1:0] r;
    unique case (s)
      CS_QX: r = qx;
      CS_QY: r = qy;
      CS_X0: r = x0;
      CS_Y0: r = y0;
      CS_X1: r = x1;
      CS_Y1: r = y1;
      CS_X2: r = x2;
      CS_Y2: r = y2;
      default: r = qx;
    endcase
    return r;
  endfunction

  assign cfg_ready  = 1'b1;
  assign in_tready  = !busy_r;
  assign in_acc     = in_tvalid && !busy_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // control word for this step
  assign uc = uc_rom(pc_r);

  // operand differences
  always_comb begin
    au = pick(uc.a_u, qx_r, qy_r, x0_r, y0_r, x1_r, y1_r, x2_r, y2_r);
    av = pick(uc.a_v, qx_r, qy_r, x0_r, y0_r, x1_r, y1_r, x2_r, y2_r);
    bu = pick(uc.b_u, qx_r, qy_r, x0_r, y0_r, x1_r, y1_r, x2_r, y2_r);
    bv = pick(uc.b_v, qx_r, qy_r, x0_r, y0_r, x1_r, y1_r, x2_r, y2_r);
    diff_a = {au[CB-1], au} - {av[CB-1], av};
    diff_b = {bu[CB-1], bu} - {bv[CB-1], bv};
  end

  // multiplier operand select
  always_comb begin
    unique case (uc.mm)
      MM_EPS_LO: begin
        mul_a = {{(MW-HW){1'b0}}, mag_r[HW-1:0]};
        mul_b = {{(MW-TOL_W){1'b0}}, tol_r};
      end
      MM_EPS_HI: begin
        mul_a = {{(MW-HW){1'b0}}, mag_r[2*HW-1:HW]};
        mul_b = {{(MW-TOL_W){1'b0}}, tol_r};
      end
      default: begin
        mul_a = {{(MW-DW){diff_a[DW-1]}}, diff_a};
        mul_b = {{(MW-DW){diff_b[DW-1]}}, diff_b};
      end
    endcase
  end

  // magnitude and tolerance test: s*p*2^32 + eps > 0
  always_comb begin
    acc_abs = acc_r[CW-1] ? -acc_r : acc_r;
    p_ext   = {acc_r[CW-1], acc_r};
    p_sgn   = flip_r ? -p_ext : p_ext;
    tsum    = {p_sgn[CW], p_sgn, {TOL_W{1'b0}}} + {{(TW-EW){1'b0}}, eps_r};
    test_ok = !tsum[TW-1] && (tsum != '0);
  end

  // bookkeeping for the vertex in flight
  always_comb begin
    tri_needed = (cnt_r >= CNT_W'(2)) && (cnt_r < CNT_MAX) && !hit_flag_r;
    tri_k      = cnt_r - CNT_W'(2);
    tri_k_sat  = (32'(tri_k) > 32'(HIT_MAX)) ? HIT_MAX : HIT_W'(tri_k);
    cnt_after  = (cnt_r < CNT_MAX) ? cnt_r + CNT_W'(1) : cnt_r;
    ovf_after  = ovf_r || (cnt_r >= CNT_MAX);
    fin_block  = last_r && out_valid_r && !out_tready;
    fin_go     = busy_r && (uc.sq == SQ_FIN) && !fin_block;
    fin_load   = fin_go && last_r;
  end

  // sequencer and polygon state next values
  always_comb begin
    busy_nxt      = busy_r;
    pc_nxt        = pc_r;
    cnt_nxt       = cnt_r;
    hit_flag_nxt  = hit_flag_r;
    hit_idx_nxt   = hit_idx_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    if (!busy_r) begin
      if (in_tvalid) begin
        busy_nxt = 1'b1;
        pc_nxt   = '0;
      end
    end else if (uc.sq == SQ_FIN) begin
      if (fin_go) begin
        busy_nxt = 1'b0;
        if (last_r) begin
          out_valid_nxt = 1'b1;
          cnt_nxt       = '0;
          hit_flag_nxt  = 1'b0;
          hit_idx_nxt   = '0;
          ovf_nxt       = 1'b0;
        end else begin
          cnt_nxt = cnt_after;
          ovf_nxt = ovf_after;
        end
      end
    end else begin
      if (uc.sq == SQ_JNT && !tri_needed) begin
        pc_nxt = uc.target;
      end else begin
        pc_nxt = pc_r + PC_W'(1);
      end
      if (uc.ao == AO_TESTHIT && pass_r && test_ok) begin
        hit_flag_nxt = 1'b1;
        hit_idx_nxt  = tri_k_sat;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pc_r        <= '0;
      cnt_r       <= '0;
      hit_flag_r  <= 1'b0;
      hit_idx_r   <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      tol_r       <= '0;
    end else begin
      busy_r      <= busy_nxt;
      pc_r        <= pc_nxt;
      cnt_r       <= cnt_nxt;
      hit_flag_r  <= hit_flag_nxt;
      hit_idx_r   <= hit_idx_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        tol_r <= cfg_data;
      end
    end
  end

  // vertex capture
  always_ff @(posedge clk) begin
    if (in_acc) begin
      x2_r   <= in_tdata[2*CB +: CB];
      y2_r   <= in_tdata[3*CB +: CB];
      last_r <= in_tlast;
      if (cnt_r == '0) begin
        qx_r <= in_tdata[0 +: CB];
        qy_r <= in_tdata[CB +: CB];
        x0_r <= in_tdata[2*CB +: CB];
        y0_r <= in_tdata[3*CB +: CB];
      end
    end
    if (fin_go && cnt_r < CNT_MAX) begin
      x1_r <= x2_r;
      y1_r <= y2_r;
    end
  end

  // shared multiplier and accumulators
  always_ff @(posedge clk) begin
    if (in_acc) begin
      pass_r <= 1'b1;
    end
    if (busy_r) begin
      mul_r <= mul_a * mul_b;
      unique case (uc.ao)
        AO_LOAD: acc_r <= mul_r[CW-1:0];
        AO_SUB:  acc_r <= acc_r - mul_r[CW-1:0];
        AO_MAGLOAD: begin
          mag_r  <= acc_abs[CW-2:0];
          flip_r <= acc_r[CW-1];
          acc_r  <= mul_r[CW-1:0];
        end
        AO_ELOAD: eps_r <= {{(EW-HW-TOL_W){1'b0}}, mul_r[HW+TOL_W-1:0]};
        AO_EADD:  eps_r <= eps_r + {mul_r[HW+TOL_W-1:0], {HW{1'b0}}};
        AO_TESTLOAD: begin
          pass_r <= pass_r && test_ok;
          acc_r  <= mul_r[CW-1:0];
        end
        AO_NONE, AO_TESTHIT: ;
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (fin_load) begin
      out_data_r.pad          <= '0;
      out_data_r.inside_res   <= hit_flag_r;
      out_data_r.hit_triangle <= hit_flag_r ? hit_idx_r : '0;
      out_data_r.too_few      <= (cnt_after < CNT_W'(3));
      out_data_r.overflow     <= ovf_after;
    end
  end

endmodule

/* design/pipft_checker.sv */
`include "assert_macros.svh"

module pipft_checker
  import pipft_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  // no result straight out of reset
  `ASSERT_NXT_ALL(a_reset_quiet, !rst_n, !out_tvalid)

  // a stalled result holds
  `ASSERT_NXT(a_stall_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // one vertex in flight: ready drops after a request
  `ASSERT_NXT(a_one_vertex, in_tvalid && in_tready, !in_tready)

  // a hit needs a real triangle
  `ASSERT_IMP(a_hit_not_few, out_tvalid && out_tdata[0], !out_tdata[7])

  // triangle index only reported with a hit
  `ASSERT_IMP(a_idx_zero, out_tvalid && !out_tdata[0], out_tdata[6:1] == 6'd0)

endmodule

bind point_in_polygon_fan_test pipft_checker u_pipft_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
